// ----- hw/rtl/oldbv_pkg.sv -----
`timescale 1ns / 1ps

package oldbv_pkg;

  localparam int DEFAULT_DEPTH = 16;
  localparam int ENTRY_W       = 32;
  localparam int STATUS_W      = 2;
  localparam int COUNT_W       = 5;

  localparam logic KIND_APPEND = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL      = 2'd2;

  typedef struct packed {
    logic                      kind;
    logic signed [ENTRY_W-1:0] value;
  } req_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COUNT_W-1:0]  entry_count;
  } rsp_t;

  typedef struct packed {
    logic                      append;
    logic                      remove;
    logic signed [ENTRY_W-1:0] value;
  } cell_ctrl_t;

endpackage

// ----- hw/rtl/ordered_list_delete_by_value.sv -----
`timescale 1ns / 1ps

// channel | signals                      | direction
// req     | req_valid, req_ready, req    | in   (kind, value)
// rsp     | rsp_valid, rsp_ready, rsp    | out  (status, entry_count)
//
// one item per cycle while the result is not stalled, result valid in the cycle after the transfer
// the match search ripples combinationally through the DEPTH cells
// rst clears the entry count and the result valid; entries are not cleared
// a stalled result holds req_ready low until it is taken

module ordered_list_delete_by_value #(
  parameter int DEPTH = oldbv_pkg::DEFAULT_DEPTH
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            req_valid,
  output logic            req_ready,
  input  oldbv_pkg::req_t req,
  output logic            rsp_valid,
  input  logic            rsp_ready,
  output oldbv_pkg::rsp_t rsp
);
  import oldbv_pkg::*;

  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [CNT_W-1:0]          count;
  logic [CNT_W-1:0]          count_next;
  logic                      accept;
  logic                      full;
  logic                      found;
  logic [STATUS_W-1:0]       status_next;
  cell_ctrl_t                ctrl;
  logic [DEPTH:0]            hit;
  logic signed [ENTRY_W-1:0] entry [DEPTH];

  assign req_ready = !rsp_valid || rsp_ready;
  assign accept    = req_valid && req_ready;
  assign full      = count == CNT_W'(DEPTH);
  assign found     = hit[DEPTH];

  assign ctrl.append = accept && (req.kind == KIND_APPEND) && !full;
  assign ctrl.remove = accept && (req.kind == KIND_REMOVE);
  assign ctrl.value  = req.value;

  assign hit[0] = 1'b0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic signed [ENTRY_W-1:0] nbr;
    if (i == DEPTH - 1) begin : g_last
      assign nbr = entry[i];
    end else begin : g_mid
      assign nbr = entry[i+1];
    end
    oldbv_cell #(
      .IDX   (i),
      .CNT_W (CNT_W)
    ) u_cell (
      .clk        (clk),
      .ctrl       (ctrl),
      .count      (count),
      .next_entry (nbr),
      .hit_in     (hit[i]),
      .hit_out    (hit[i+1]),
      .entry      (entry[i])
    );
  end

  always_comb begin
    count_next  = count;
    status_next = ST_DONE;
    if (req.kind == KIND_APPEND) begin
      if (full) begin
        status_next = ST_FULL;
      end else begin
        count_next = count + CNT_W'(1);
      end
    end else begin
      if (found) begin
        count_next = count - CNT_W'(1);
      end else begin
        status_next = ST_NOT_FOUND;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count     <= '0;
      rsp_valid <= 1'b0;
    end else if (accept) begin
      count           <= count_next;
      rsp_valid       <= 1'b1;
      rsp.status      <= status_next;
      rsp.entry_count <= COUNT_W'(count_next);
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

endmodule

// ----- hw/rtl/oldbv_cell.sv -----
`timescale 1ns / 1ps

module oldbv_cell #(
  parameter int IDX   = 0,
  parameter int CNT_W = 5
) (
  input  logic                               clk,
  input  oldbv_pkg::cell_ctrl_t              ctrl,
  input  logic [CNT_W-1:0]                   count,
  input  logic signed [oldbv_pkg::ENTRY_W-1:0] next_entry,
  input  logic                               hit_in,
  output logic                               hit_out,
  output logic signed [oldbv_pkg::ENTRY_W-1:0] entry
);
  import oldbv_pkg::*;

  logic active;
  logic match;
  logic shift;
  logic load;

  assign active  = CNT_W'(IDX) < count;
  assign match   = active && (entry == ctrl.value);
  assign hit_out = hit_in | match;
  assign shift   = ctrl.remove & hit_out;
  assign load    = ctrl.append & (count == CNT_W'(IDX));

  always_ff @(posedge clk) begin
    if (shift) begin
      entry <= next_entry;
    end else if (load) begin
      entry <= ctrl.value;
    end
  end

endmodule

// ----- hw/rtl/oldbv_check.sv -----
`timescale 1ns / 1ps

module oldbv_check #(
  parameter int DEPTH = oldbv_pkg::DEFAULT_DEPTH
) (
  input logic            clk,
  input logic            rst,
  input logic            req_valid,
  input logic            req_ready,
  input logic            rsp_valid,
  input logic            rsp_ready,
  input oldbv_pkg::rsp_t rsp
);
  import oldbv_pkg::*;

  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp))
    else $error("result changed while stalled");

  a_ready_after_reset: assert property (@(posedge clk)
    rst |=> req_ready && !rsp_valid)
    else $error("not ready after reset");

  a_transfer_gives_result: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> rsp_valid)
    else $error("transfer without result");

  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && (rsp.status == ST_FULL) |-> rsp.entry_count == COUNT_W'(DEPTH))
    else $error("full status with wrong count");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (rsp.status == ST_DONE) || (rsp.status == ST_NOT_FOUND) ||
                  (rsp.status == ST_FULL))
    else $error("bad status code");

endmodule

bind ordered_list_delete_by_value oldbv_check #(.DEPTH(DEPTH)) u_check (.*);
